// ===== rtl/core/gse_pkg.sv =====
// gse_pkg: shared sizes, codes and interface structs of the growing stack engine
// no dependencies; used by every module in rtl/core
`timescale 1ns / 1ps
`default_nettype none

package gse_pkg;

	// storage geometry
	localparam int unsigned DEPTH      = 1024;
	localparam int unsigned ADDR_W     = $clog2(DEPTH);
	localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

	// field widths
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned CAP_W      = 24;
	localparam int unsigned INIT_W     = 11;
	localparam int unsigned GF_W       = 5;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned STAT_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// capacity saturation limit
	localparam logic [CAP_W-1:0] CAP_MAX = 24'hFFFFFF;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GROWTH   = 2'd1;

	// configuration write as seen by the capacity unit
	typedef struct packed {
		logic                  wr;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// stack operation that may move the capacity
	typedef struct packed {
		logic             push_ok;
		logic             pop_ok;
		logic [CNT_W-1:0] count;
	} cap_op_t;

endpackage

`default_nettype wire

// ===== rtl/core/gse_stack_mem.sv =====
// gse_stack_mem: word store of the stack, one write port and one registered read port
// depends on gse_pkg for depth and word width
`timescale 1ns / 1ps
`default_nettype none

module gse_stack_mem (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [gse_pkg::ADDR_W-1:0] wr_addr,
	input  wire logic [gse_pkg::DATA_W-1:0] wr_data,
	input  wire logic                       rd_en,
	input  wire logic [gse_pkg::ADDR_W-1:0] rd_addr,
	output logic      [gse_pkg::DATA_W-1:0] rd_data
);

	logic [gse_pkg::DATA_W-1:0] mem_q [gse_pkg::DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, data registered and held when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gse_cap_unit.sv =====
// gse_cap_unit: logical capacity and growth factor registers with grow and shrink logic
// depends on gse_pkg for widths, register indexes and the cfg_wr_t and cap_op_t structs
`timescale 1ns / 1ps
`default_nettype none

module gse_cap_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire gse_pkg::cfg_wr_t          cfg,
	input  wire gse_pkg::cap_op_t          op,
	output logic      [gse_pkg::CAP_W-1:0] cap_next
);

	localparam logic [gse_pkg::INIT_W-1:0] INIT_CAP_RST = 11'd5;
	localparam logic [gse_pkg::GF_W-1:0]   GROWTH_RST   = 5'd3;
	localparam logic [gse_pkg::GF_W-1:0]   GROWTH_MIN   = 5'd2;
	localparam int unsigned                PROD_W       = gse_pkg::CAP_W + gse_pkg::GF_W;

	logic [gse_pkg::CAP_W-1:0] cap_q;
	logic [gse_pkg::GF_W-1:0]  growth_q;
	logic [PROD_W-1:0]         prod;
	logic [gse_pkg::CAP_W-1:0] grown;
	logic [gse_pkg::CAP_W-1:0] half;
	logic [gse_pkg::CAP_W-1:0] cnt_ext;
	logic [gse_pkg::CAP_W-1:0] cap_load;
	logic [gse_pkg::GF_W-1:0]  growth_load;
	logic                      ld_cap;
	logic                      ld_growth;

	// clamp a loaded capacity into one .. CAP_MAX
	function automatic logic [gse_pkg::CAP_W-1:0] clamp_cap(
		input logic [gse_pkg::INIT_W-1:0] v
	);
		logic [gse_pkg::CAP_W-1:0] ext;
		ext = gse_pkg::CAP_W'(v);
		if (ext == '0) begin
			return gse_pkg::CAP_W'(1);
		end else if (ext > gse_pkg::CAP_MAX) begin
			return gse_pkg::CAP_MAX;
		end
		return ext;
	endfunction

	// grow path: saturating multiply by the growth factor
	assign prod  = PROD_W'(cap_q) * PROD_W'(growth_q);
	assign grown = (prod > PROD_W'(gse_pkg::CAP_MAX)) ? gse_pkg::CAP_MAX
	                                                  : prod[gse_pkg::CAP_W-1:0];

	// shrink path: halve and add one
	assign half    = cap_q >> 1;
	assign cnt_ext = gse_pkg::CAP_W'(op.count);

	// capacity after this item
	always_comb begin
		cap_next = cap_q;
		if (op.push_ok && (cnt_ext >= cap_q)) begin
			cap_next = grown;
		end else if (op.pop_ok && ((cnt_ext - gse_pkg::CAP_W'(1)) <= half)) begin
			cap_next = half + gse_pkg::CAP_W'(1);
		end
	end

	// register writes
	assign ld_cap      = cfg.wr && (cfg.index == gse_pkg::REG_INIT_CAP);
	assign ld_growth   = cfg.wr && (cfg.index == gse_pkg::REG_GROWTH);
	assign cap_load    = clamp_cap(cfg.data[gse_pkg::INIT_W-1:0]);
	assign growth_load = (cfg.data[gse_pkg::GF_W-1:0] < GROWTH_MIN) ? GROWTH_MIN
	                                                                : cfg.data[gse_pkg::GF_W-1:0];

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= clamp_cap(INIT_CAP_RST);
			growth_q <= GROWTH_RST;
		end else begin
			if (ld_cap) begin
				cap_q <= cap_load;
			end else begin
				cap_q <= cap_next;
			end
			if (ld_growth) begin
				growth_q <= growth_load;
			end
		end
	end

	// checks
	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q != '0) && (cap_q <= gse_pkg::CAP_MAX))
		else $error("capacity left its legal range");

	a_growth_min: assert property (@(posedge clk) disable iff (!arst_n)
		growth_q >= GROWTH_MIN)
		else $error("growth factor below two");

	a_shrink_down: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop_ok && !cfg.wr |=> cap_q <= $past(cap_q))
		else $error("capacity grew on a pop");

	a_grow_up: assert property (@(posedge clk) disable iff (!arst_n)
		op.push_ok && !cfg.wr |=> cap_q >= $past(cap_q))
		else $error("capacity shrank on a push");

endmodule

`default_nettype wire

// ===== rtl/core/growing_stack_engine_top.sv =====
// growing_stack_engine_top: stack of signed words with logical capacity tracking
// path: input register, then result register; out_stall on a valid result stalls both
// throughput: one item per cycle unless out_stall holds a result; the pop path sets it, the
//   new top comes from a cached register, the entry below it from a registered store read
//   after a pop or from the pushed-over top after a push
// reset: count cleared, capacity 5, growth factor 3; store contents stay undefined
// depends on gse_pkg, gse_stack_mem and gse_cap_unit
`timescale 1ns / 1ps
`default_nettype none

module growing_stack_engine_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// input items
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic        [gse_pkg::MODE_W-1:0]    mode,
	input  wire logic signed [gse_pkg::DATA_W-1:0]    push_value,
	// result items
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [gse_pkg::DATA_W-1:0]    read_value,
	output logic             [gse_pkg::STAT_W-1:0]    status,
	output logic             [gse_pkg::CNT_W-1:0]     item_count,
	output logic             [gse_pkg::CAP_W-1:0]     logical_capacity,
	// register writes
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic        [gse_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic        [gse_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam logic [gse_pkg::CNT_W-1:0] CNT_FULL = gse_pkg::CNT_W'(gse_pkg::DEPTH);

	// input stage
	logic                         valid_s1;
	logic [gse_pkg::MODE_W-1:0]   mode_s1;
	logic [gse_pkg::DATA_W-1:0]   value_s1;

	// stack state
	logic [gse_pkg::CNT_W-1:0]    count_q;
	logic [gse_pkg::CNT_W-1:0]    count_next;
	logic [gse_pkg::DATA_W-1:0]   top_q;
	logic [gse_pkg::DATA_W-1:0]   byp_q;
	logic                         below_sel_q;
	logic [gse_pkg::DATA_W-1:0]   below;
	logic [gse_pkg::DATA_W-1:0]   mem_rd;
	logic [gse_pkg::CNT_W-1:0]    rd_ptr;

	// result register
	logic                         out_valid_q;
	logic [gse_pkg::DATA_W-1:0]   read_value_q;
	logic [gse_pkg::STAT_W-1:0]   status_q;
	logic [gse_pkg::CNT_W-1:0]    item_count_q;
	logic [gse_pkg::CAP_W-1:0]    capacity_q;

	// decode
	logic                         adv;
	logic                         fire;
	logic                         is_push;
	logic                         is_pop;
	logic                         is_peek;
	logic                         full;
	logic                         empty;
	logic                         push_ok;
	logic                         pop_ok;
	logic                         cfg_clear;
	logic [gse_pkg::DATA_W-1:0]   res_value;
	logic [gse_pkg::STAT_W-1:0]   res_status;
	logic [gse_pkg::CAP_W-1:0]    cap_next;
	gse_pkg::cfg_wr_t             cfg_wr;
	gse_pkg::cap_op_t             cap_op;

	// handshakes
	assign adv       = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && adv;
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1  <= mode;
			value_s1 <= push_value;
		end
	end

	// operation decode
	assign is_push = (mode_s1 == gse_pkg::MODE_PUSH);
	assign is_pop  = (mode_s1 == gse_pkg::MODE_POP);
	assign is_peek = (mode_s1 == gse_pkg::MODE_PEEK);
	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign push_ok = fire && is_push && !full;
	assign pop_ok  = fire && is_pop && !empty;

	// entry below the top: last pushed-over top or a fresh store read
	assign below  = below_sel_q ? mem_rd : byp_q;
	assign rd_ptr = count_q - gse_pkg::CNT_W'(3);

	// result of this item
	always_comb begin
		res_value  = '0;
		res_status = gse_pkg::ST_OK;
		if (is_push && full) begin
			res_status = gse_pkg::ST_OVER;
		end else if ((is_pop || is_peek) && empty) begin
			res_status = gse_pkg::ST_UNDER;
		end else if (is_pop || is_peek) begin
			res_value = top_q;
		end
	end

	always_comb begin
		count_next = count_q;
		if (push_ok) begin
			count_next = count_q + gse_pkg::CNT_W'(1);
		end else if (pop_ok) begin
			count_next = count_q - gse_pkg::CNT_W'(1);
		end
	end

	// configuration and capacity
	assign cfg_wr.wr    = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;
	assign cfg_clear    = cfg_wr.wr && (cfg_index == gse_pkg::REG_INIT_CAP);

	assign cap_op.push_ok = push_ok;
	assign cap_op.pop_ok  = pop_ok;
	assign cap_op.count   = count_q;

	gse_cap_unit u_cap (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_wr),
		.op       (cap_op),
		.cap_next (cap_next)
	);

	// word store
	gse_stack_mem u_mem (
		.clk     (clk),
		.wr_en   (push_ok),
		.wr_addr (count_q[gse_pkg::ADDR_W-1:0]),
		.wr_data (value_s1),
		.rd_en   (pop_ok),
		.rd_addr (rd_ptr[gse_pkg::ADDR_W-1:0]),
		.rd_data (mem_rd)
	);

	// count and below-source select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			below_sel_q <= 1'b0;
		end else begin
			if (cfg_clear) begin
				count_q <= '0;
			end else begin
				count_q <= count_next;
			end
			if (push_ok) begin
				below_sel_q <= 1'b0;
			end else if (pop_ok) begin
				below_sel_q <= 1'b1;
			end
		end
	end

	// cached top of stack
	always_ff @(posedge clk) begin
		if (push_ok) begin
			top_q <= value_s1;
			byp_q <= top_q;
		end else if (pop_ok) begin
			top_q <= below;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_value_q <= res_value;
			status_q     <= res_status;
			item_count_q <= count_next;
			capacity_q   <= cap_next;
		end
	end

	assign out_valid        = out_valid_q;
	assign read_value       = read_value_q;
	assign status           = status_q;
	assign item_count       = item_count_q;
	assign logical_capacity = capacity_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("word count above store depth");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == gse_pkg::ST_OVER) |-> item_count_q == CNT_FULL)
		else $error("overflow reported on a store that is not full");

	a_under_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == gse_pkg::ST_UNDER)
		|-> (item_count_q == '0) && (read_value_q == '0))
		else $error("underflow reported on a non-empty stack");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok && !cfg_clear |=> count_q == $past(count_q) + gse_pkg::CNT_W'(1))
		else $error("push did not advance the count");

endmodule

`default_nettype wire
